@@ rtl/tvp_pkg.sv @@
package tvp_pkg;

	localparam int POS_W = 32;
	localparam int VEL_W = 24;
	localparam int ACC_W = 16;

	localparam logic [ACC_W-1:0] ACCEL_RESET = 16'd655;

	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef enum logic [1:0] {
		PH_RUN    = 2'd0,
		PH_DECEL  = 2'd1,
		PH_FINISH = 2'd2
	} phase_t;

	typedef struct packed {
		logic                    action;
		logic signed [POS_W-1:0] target_position;
		logic        [VEL_W-1:0] cruise_velocity;
		logic        [VEL_W-1:0] end_velocity;
	} cmd_item_t;

	typedef struct packed {
		logic        [VEL_W-1:0] velocity;
		logic signed [POS_W-1:0] position;
		logic        [1:0]       phase;
		logic                    start_accepted;
	} rsp_item_t;

endpackage

@@ rtl/trapezoid_velocity_profiler.sv @@
// An accepted item is registered in cmd_s1 and its result item in rsp_q when it advances.
// Throughput: one item per cycle unless rsp_stall holds a full output. The profile
// state loop is combinational through the brake-test multipliers, ramp and position adder.
// Reset (arst_n low, asynchronous): phase finished, velocity, position, limit,
// end velocity and target cleared, accel_q set to 655, both stages empty.
module trapezoid_velocity_profiler (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tvp_pkg::ACC_W-1:0]  cfg_wdata,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  tvp_pkg::cmd_item_t         cmd,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output tvp_pkg::rsp_item_t         rsp
);

	localparam int PW  = tvp_pkg::POS_W;
	localparam int VW  = tvp_pkg::VEL_W;
	localparam int AW  = tvp_pkg::ACC_W;
	localparam int LW  = 2 * VW + 1;
	localparam int RW  = AW + 1 + PW + 1;
	localparam int CW  = (LW > RW) ? LW : RW;

	logic [AW-1:0]      accel_q;
	tvp_pkg::phase_t    phase_q;
	logic [VW-1:0]      vel_q;
	logic [PW-1:0]      pos_q;
	logic [VW-1:0]      lim_q;
	logic [VW-1:0]      vend_q;
	logic [PW-1:0]      tgt_q;

	logic               valid_s1;
	tvp_pkg::cmd_item_t cmd_s1;
	logic               rsp_valid_q;
	tvp_pkg::rsp_item_t rsp_q;
	logic               adv;

	// Brake test and tick update.
	logic               neg_l;
	logic [VW-1:0]      diff;
	logic [VW:0]        vsum;
	logic [LW-1:0]      ml;
	logic signed [PW:0] remain;
	logic               neg_r;
	logic [PW:0]        mag;
	logic [RW-1:0]      mr;
	logic [CW-1:0]      ml_x;
	logic [CW-1:0]      mr_x;
	logic               nl;
	logic               nr;
	logic               brake;
	logic [VW-1:0]      accel_x;

	tvp_pkg::phase_t    phase_n;
	logic [VW-1:0]      vel_n;
	logic [PW-1:0]      pos_n;
	logic [VW-1:0]      lim_n;
	logic [VW-1:0]      vend_n;
	logic [PW-1:0]      tgt_n;
	logic               started;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall = valid_s1 && !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		neg_l   = vel_q < vend_q;
		diff    = neg_l ? (vend_q - vel_q) : (vel_q - vend_q);
		vsum    = {1'b0, vel_q} + {1'b0, vend_q};
		ml      = LW'({1'b0, diff} * vsum);
		remain  = $signed({tgt_q[PW-1], tgt_q}) - $signed({pos_q[PW-1], pos_q});
		neg_r   = remain[PW];
		mag     = neg_r ? (PW+1)'(-remain) : (PW+1)'(remain);
		mr      = RW'({accel_q, 1'b0} * mag);
		ml_x    = CW'(ml);
		mr_x    = CW'(mr);
		// A zero product counts as non-negative on either side.
		nl      = neg_l && (ml_x != '0);
		nr      = neg_r && (mr_x != '0);
		if (nl && !nr) begin
			brake = 1'b0;
		end else if (!nl && nr) begin
			brake = 1'b1;
		end else if (!nl) begin
			brake = ml_x >= mr_x;
		end else begin
			brake = ml_x <= mr_x;
		end
		accel_x = VW'(accel_q);
	end

	always_comb begin
		phase_n = phase_q;
		vel_n   = vel_q;
		pos_n   = pos_q;
		lim_n   = lim_q;
		vend_n  = vend_q;
		tgt_n   = tgt_q;
		started = 1'b0;
		if (cmd_s1.action == tvp_pkg::ACT_START) begin
			if (phase_q == tvp_pkg::PH_FINISH) begin
				tgt_n   = cmd_s1.target_position;
				lim_n   = cmd_s1.cruise_velocity;
				vend_n  = cmd_s1.end_velocity;
				phase_n = tvp_pkg::PH_RUN;
				started = 1'b1;
			end
		end else begin
			if (phase_q == tvp_pkg::PH_RUN && brake) begin
				phase_n = tvp_pkg::PH_DECEL;
				lim_n   = vend_q;
			end
			// Position at or past the target is the same as a non-positive distance.
			if (neg_r || remain == '0 || (phase_n == tvp_pkg::PH_DECEL && vel_q == '0)) begin
				phase_n = tvp_pkg::PH_FINISH;
				lim_n   = vend_q;
			end
			if (vel_q < lim_n) begin
				vel_n = ((lim_n - vel_q) <= accel_x) ? lim_n : (vel_q + accel_x);
			end else if (vel_q > lim_n) begin
				vel_n = ((vel_q - lim_n) <= accel_x) ? lim_n : (vel_q - accel_x);
			end
			pos_n = pos_q + PW'(vel_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q     <= tvp_pkg::ACCEL_RESET;
			phase_q     <= tvp_pkg::PH_FINISH;
			vel_q       <= '0;
			pos_q       <= '0;
			lim_q       <= '0;
			vend_q      <= '0;
			tgt_q       <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				accel_q <= cfg_wdata;
			end
			if (!cmd_stall) begin
				valid_s1 <= cmd_valid;
			end
			if (adv) begin
				phase_q     <= phase_n;
				vel_q       <= vel_n;
				pos_q       <= pos_n;
				lim_q       <= lim_n;
				vend_q      <= vend_n;
				tgt_q       <= tgt_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (adv) begin
			rsp_q.velocity       <= vel_n;
			rsp_q.position       <= pos_n;
			rsp_q.phase          <= phase_n;
			rsp_q.start_accepted <= started;
		end
	end

	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.start_accepted |-> rsp.phase == tvp_pkg::PH_RUN)
		else $error("accepted start item not reported in run phase");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && rsp_valid_q && rsp_stall)
		else $error("input stalled while the pipeline can move");

	a_start_no_motion: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1.action == tvp_pkg::ACT_START |=> $stable(vel_q) && $stable(pos_q))
		else $error("start item changed velocity or position");

	a_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp) && $stable(phase_q))
		else $error("stalled result item or profile state changed");

endmodule
